// ===== design/scb_pkg.sv =====
// Shared constants and types for the shifted channel blend block.
package scb_pkg;

  localparam int MAX_WIDTH_DEF      = 1024;
  localparam int RED_ROWS_BACK_DEF  = 5;
  localparam int RED_COLS_AHEAD_DEF = 10;
  localparam int BLUE_ROWS_BACK_DEF = 10;
  localparam int BLUE_COLS_BACK_DEF = 5;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int ROW_W  = 12;
  localparam int CFG_W  = 13;
  localparam int SUM_W  = 12;

  localparam int MAX_HEIGHT = 4096;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Floor division by ten for sums below 4096: (v * 52429) >> 19.
  localparam int               DIV10_SHIFT = 19;
  localparam int               PROD_W      = 28;
  localparam logic [15:0]      DIV10_MUL   = 16'd52429;

  typedef struct packed {
    logic red_en;
    logic blue_en;
    logic last;
  } scb_flags_t;

endpackage

// ===== design/scb_line_store.sv =====
// Ring of past rows for one color channel, one write and one registered read per cycle.
module scb_line_store #(
  parameter int SLOTS = 5,
  parameter int DEPTH = scb_pkg::MAX_WIDTH_DEF,
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [SW-1:0]            wr_slot_i,
  input  logic [CW-1:0]            wr_col_i,
  input  logic [scb_pkg::PIX_W-1:0] wr_data_i,
  input  logic                     rd_en_i,
  input  logic [SW-1:0]            rd_slot_i,
  input  logic [CW-1:0]            rd_col_i,
  output logic [scb_pkg::PIX_W-1:0] rd_data_o
);

  logic [scb_pkg::PIX_W-1:0] mem [SLOTS][DEPTH];
  logic [scb_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_slot_i][wr_col_i] <= wr_data_i;
    end
  end

  // Read and write never hit the same entry in one cycle, so no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_slot_i][rd_col_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/scb_coord.sv =====
// Column, row and line store slot tracking for the incoming pixel stream.
module scb_coord #(
  parameter int MAX_WIDTH      = scb_pkg::MAX_WIDTH_DEF,
  parameter int RED_ROWS_BACK  = scb_pkg::RED_ROWS_BACK_DEF,
  parameter int RED_COLS_AHEAD = scb_pkg::RED_COLS_AHEAD_DEF,
  parameter int BLUE_ROWS_BACK = scb_pkg::BLUE_ROWS_BACK_DEF,
  parameter int BLUE_COLS_BACK = scb_pkg::BLUE_COLS_BACK_DEF,
  localparam int RED_SLOTS  = RED_ROWS_BACK,
  localparam int BLUE_SLOTS = BLUE_ROWS_BACK + 1,
  localparam int RSW = (RED_SLOTS > 1) ? $clog2(RED_SLOTS) : 1,
  localparam int BSW = $clog2(BLUE_SLOTS),
  localparam int CW  = $clog2(MAX_WIDTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        frame_start_i,
  input  logic [scb_pkg::FW_W-1:0]    frame_width_i,
  input  logic [scb_pkg::FH_W-1:0]    frame_height_i,
  output scb_pkg::scb_flags_t         flags_o,
  output logic [CW-1:0]               col_o,
  output logic [RSW-1:0]              red_slot_o,
  output logic [CW-1:0]               red_rd_col_o,
  output logic [BSW-1:0]              blue_wr_slot_o,
  output logic [BSW-1:0]              blue_rd_slot_o,
  output logic [CW-1:0]               blue_rd_col_o
);

  localparam int EW = ($clog2(MAX_WIDTH + 1) > scb_pkg::FW_W) ?
                      $clog2(MAX_WIDTH + 1) : scb_pkg::FW_W;
  localparam int HW = scb_pkg::FH_W;
  localparam logic [BSW-1:0] BRD_INIT = BSW'(1 % BLUE_SLOTS);

  logic [CW-1:0]              col_q, col_d;
  logic [scb_pkg::ROW_W-1:0]  row_q, row_d;
  logic [RSW-1:0]             rslot_q, rslot_d;
  logic [BSW-1:0]             bwslot_q, bwslot_d;
  logic [BSW-1:0]             brslot_q, brslot_d;

  logic [EW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic            col_clr, row_clr;
  logic [CW-1:0]   x;
  logic [scb_pkg::ROW_W-1:0] y;
  logic [EW-1:0]   xe;
  logic [EW:0]     x_plus1, x_plus_c;
  logic [HW-1:0]   y_plus1;
  logic            row_end, frame_wrap;
  logic [RSW-1:0]  rslot_cur;
  logic [BSW-1:0]  bwslot_cur, brslot_cur;

  // Zero sizes act as one; sizes above the maximum are clamped to it.
  always_comb begin
    if (frame_width_i == '0) begin
      w_eff = EW'(1);
    end else if (EW'(frame_width_i) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      h_eff = HW'(1);
    end else if (frame_height_i > HW'(scb_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(scb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height_i;
    end
  end

  assign col_clr = frame_start_i || (EW'(col_q) >= w_eff);
  assign row_clr = frame_start_i || (HW'(row_q) >= h_eff);
  assign x = col_clr ? '0 : col_q;
  assign y = row_clr ? '0 : row_q;
  assign rslot_cur  = row_clr ? '0 : rslot_q;
  assign bwslot_cur = row_clr ? '0 : bwslot_q;
  assign brslot_cur = row_clr ? BRD_INIT : brslot_q;

  assign xe       = EW'(x);
  assign x_plus1  = (EW+1)'(xe) + (EW+1)'(1);
  assign x_plus_c = (EW+1)'(xe) + (EW+1)'(RED_COLS_AHEAD);
  assign y_plus1  = HW'(y) + HW'(1);

  assign row_end    = x_plus1 >= (EW+1)'(w_eff);
  assign frame_wrap = y_plus1 >= h_eff;

  assign flags_o.red_en  = (y > scb_pkg::ROW_W'(RED_ROWS_BACK)) &&
                           (x_plus_c < (EW+1)'(w_eff));
  assign flags_o.blue_en = (y > scb_pkg::ROW_W'(BLUE_ROWS_BACK)) &&
                           (xe > EW'(BLUE_COLS_BACK));
  assign flags_o.last    = (x_plus1 == (EW+1)'(w_eff)) && (y_plus1 == h_eff);

  assign col_o          = x;
  assign red_slot_o     = rslot_cur;
  assign red_rd_col_o   = CW'(x_plus_c);
  assign blue_wr_slot_o = bwslot_cur;
  assign blue_rd_slot_o = brslot_cur;
  assign blue_rd_col_o  = CW'(xe - EW'(BLUE_COLS_BACK));

  always_comb begin
    col_d    = CW'(x_plus1);
    row_d    = y;
    rslot_d  = rslot_cur;
    bwslot_d = bwslot_cur;
    brslot_d = brslot_cur;
    if (row_end) begin
      col_d = '0;
      if (frame_wrap) begin
        row_d    = '0;
        rslot_d  = '0;
        bwslot_d = '0;
        brslot_d = BRD_INIT;
      end else begin
        row_d    = scb_pkg::ROW_W'(y_plus1);
        rslot_d  = (rslot_cur == RSW'(RED_SLOTS - 1)) ? '0 : rslot_cur + RSW'(1);
        bwslot_d = (bwslot_cur == BSW'(BLUE_SLOTS - 1)) ? '0 : bwslot_cur + BSW'(1);
        brslot_d = (brslot_cur == BSW'(BLUE_SLOTS - 1)) ? '0 : brslot_cur + BSW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      rslot_q  <= '0;
      bwslot_q <= '0;
      brslot_q <= BRD_INIT;
    end else if (accept_i) begin
      col_q    <= col_d;
      row_q    <= row_d;
      rslot_q  <= rslot_d;
      bwslot_q <= bwslot_d;
      brslot_q <= brslot_d;
    end
  end

  // The blue read slot always runs one slot ahead of the write slot.
  a_blue_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brslot_q == ((bwslot_q == BSW'(BLUE_SLOTS - 1)) ? '0 : bwslot_q + BSW'(1)))
    else $error("blue read slot out of step with write slot");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && flags_o.last) |=> (col_q == '0 && row_q == '0))
    else $error("coordinates did not wrap after last pixel");

endmodule

// ===== design/scb_blend.sv =====
// Two stage blend: weighted sum, then divide by ten into the output register.
module scb_blend (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [scb_pkg::PIX_W-1:0]   red_far_i,
  input  logic [scb_pkg::PIX_W-1:0]   red_here_i,
  input  logic [scb_pkg::PIX_W-1:0]   green_i,
  input  logic [scb_pkg::PIX_W-1:0]   blue_far_i,
  input  logic [scb_pkg::PIX_W-1:0]   blue_here_i,
  input  scb_pkg::scb_flags_t         flags_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scb_pkg::PIX_W-1:0]   red_o,
  output logic [scb_pkg::PIX_W-1:0]   green_o,
  output logic [scb_pkg::PIX_W-1:0]   blue_o,
  output logic                        last_o
);

  localparam int SW = scb_pkg::SUM_W;
  localparam int PW = scb_pkg::PROD_W;

  logic                      v2_q, v3_q;
  logic                      en2, en3;
  logic [SW-1:0]             red_sum_d, blue_sum_d;
  logic [SW-1:0]             red_sum_q, blue_sum_q;
  logic [scb_pkg::PIX_W-1:0] green2_q;
  logic                      last2_q;
  logic [PW-1:0]             red_prod, blue_prod;
  logic [scb_pkg::PIX_W-1:0] red3_q, green3_q, blue3_q;
  logic                      last3_q;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign in_stall_o = !en2;

  // A channel that is not blended uses ten times itself, so the divide returns it unchanged.
  always_comb begin
    if (flags_i.red_en) begin
      red_sum_d = SW'(red_far_i) * SW'(7) + SW'(red_here_i) * SW'(3);
    end else begin
      red_sum_d = SW'(red_here_i) * SW'(10);
    end
    if (flags_i.blue_en) begin
      blue_sum_d = SW'(blue_far_i) * SW'(7) + SW'(blue_here_i) * SW'(3);
    end else begin
      blue_sum_d = SW'(blue_here_i) * SW'(10);
    end
  end

  assign red_prod  = PW'(red_sum_q) * PW'(scb_pkg::DIV10_MUL);
  assign blue_prod = PW'(blue_sum_q) * PW'(scb_pkg::DIV10_MUL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= in_valid_i;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      red_sum_q  <= red_sum_d;
      blue_sum_q <= blue_sum_d;
      green2_q   <= green_i;
      last2_q    <= flags_i.last;
    end
    if (en3) begin
      red3_q   <= red_prod[scb_pkg::DIV10_SHIFT +: scb_pkg::PIX_W];
      blue3_q  <= blue_prod[scb_pkg::DIV10_SHIFT +: scb_pkg::PIX_W];
      green3_q <= green2_q;
      last3_q  <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign red_o       = red3_q;
  assign green_o     = green3_q;
  assign blue_o      = blue3_q;
  assign last_o      = last3_q;

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && en3) |=> v3_q)
    else $error("item lost between sum and output stage");

endmodule

// ===== design/shifted_channel_blend.sv =====
// Top level of the shifted channel blend: config registers, line stores and pipeline.
// An accepted item passes through the input stage, the sum stage and the output register.
// Throughput: one item per cycle when not stalled; line stores write and read once per cycle.
// Stalls collapse bubbles, so input is refused only when all three stages hold items.
// Reset clears the coordinates and sets the frame size to 640 by 480.
// The line stores are not cleared; no clearing pass runs and items are taken at once.
module shifted_channel_blend #(
  parameter int MAX_WIDTH      = scb_pkg::MAX_WIDTH_DEF,
  parameter int RED_ROWS_BACK  = scb_pkg::RED_ROWS_BACK_DEF,
  parameter int RED_COLS_AHEAD = scb_pkg::RED_COLS_AHEAD_DEF,
  parameter int BLUE_ROWS_BACK = scb_pkg::BLUE_ROWS_BACK_DEF,
  parameter int BLUE_COLS_BACK = scb_pkg::BLUE_COLS_BACK_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic [scb_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [scb_pkg::PIX_W-1:0]   red_in_i,
  input  logic [scb_pkg::PIX_W-1:0]   green_in_i,
  input  logic [scb_pkg::PIX_W-1:0]   blue_in_i,
  input  logic                        frame_start_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scb_pkg::PIX_W-1:0]   red_out_o,
  output logic [scb_pkg::PIX_W-1:0]   green_out_o,
  output logic [scb_pkg::PIX_W-1:0]   blue_out_o,
  output logic                        frame_end_o
);

  localparam int RED_SLOTS  = RED_ROWS_BACK;
  localparam int BLUE_SLOTS = BLUE_ROWS_BACK + 1;
  localparam int RSW = (RED_SLOTS > 1) ? $clog2(RED_SLOTS) : 1;
  localparam int BSW = $clog2(BLUE_SLOTS);
  localparam int CW  = $clog2(MAX_WIDTH);

  logic [scb_pkg::FW_W-1:0] frame_width_q;
  logic [scb_pkg::FH_W-1:0] frame_height_q;

  logic                 accept, en1, blend_stall;
  logic                 s1_valid_q;
  scb_pkg::scb_flags_t  flags, s1_flags_q;
  logic [CW-1:0]        col;
  logic [RSW-1:0]       red_slot;
  logic [CW-1:0]        red_rd_col;
  logic [BSW-1:0]       blue_wr_slot, blue_rd_slot;
  logic [CW-1:0]        blue_rd_col;
  logic [scb_pkg::PIX_W-1:0] red_far, blue_far;
  logic [scb_pkg::PIX_W-1:0] s1_red_q, s1_green_q, s1_blue_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= scb_pkg::FRAME_WIDTH_RST;
      frame_height_q <= scb_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        scb_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[scb_pkg::FW_W-1:0];
        scb_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en1        = !s1_valid_q || !blend_stall;
  assign in_stall_o = !en1;
  assign accept     = in_valid_i && en1;

  scb_coord #(
    .MAX_WIDTH      (MAX_WIDTH),
    .RED_ROWS_BACK  (RED_ROWS_BACK),
    .RED_COLS_AHEAD (RED_COLS_AHEAD),
    .BLUE_ROWS_BACK (BLUE_ROWS_BACK),
    .BLUE_COLS_BACK (BLUE_COLS_BACK)
  ) u_coord (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_start_i  (frame_start_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .flags_o        (flags),
    .col_o          (col),
    .red_slot_o     (red_slot),
    .red_rd_col_o   (red_rd_col),
    .blue_wr_slot_o (blue_wr_slot),
    .blue_rd_slot_o (blue_rd_slot),
    .blue_rd_col_o  (blue_rd_col)
  );

  // The red ring has one slot per row of lag, so a row is read in the slot it overwrites later.
  scb_line_store #(
    .SLOTS (RED_SLOTS),
    .DEPTH (MAX_WIDTH)
  ) u_red_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_slot_i (red_slot),
    .wr_col_i  (col),
    .wr_data_i (red_in_i),
    .rd_en_i   (en1),
    .rd_slot_i (red_slot),
    .rd_col_i  (red_rd_col),
    .rd_data_o (red_far)
  );

  scb_line_store #(
    .SLOTS (BLUE_SLOTS),
    .DEPTH (MAX_WIDTH)
  ) u_blue_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_slot_i (blue_wr_slot),
    .wr_col_i  (col),
    .wr_data_i (blue_in_i),
    .rd_en_i   (en1),
    .rd_slot_i (blue_rd_slot),
    .rd_col_i  (blue_rd_col),
    .rd_data_o (blue_far)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_red_q   <= red_in_i;
      s1_green_q <= green_in_i;
      s1_blue_q  <= blue_in_i;
      s1_flags_q <= flags;
    end
  end

  scb_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_stall_o  (blend_stall),
    .red_far_i   (red_far),
    .red_here_i  (s1_red_q),
    .green_i     (s1_green_q),
    .blue_far_i  (blue_far),
    .blue_here_i (s1_blue_q),
    .flags_i     (s1_flags_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_out_o),
    .green_o     (green_out_o),
    .blue_o      (blue_out_o),
    .last_o      (frame_end_o)
  );

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

endmodule

// ===== sim/scb_blend_checker.sv =====
// Checker for the shifted channel blend: predicts every output pixel and compares it.
module scb_blend_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic                      cfg_index_i,
  input  logic [scb_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [scb_pkg::PIX_W-1:0] red_in_i,
  input  logic [scb_pkg::PIX_W-1:0] green_in_i,
  input  logic [scb_pkg::PIX_W-1:0] blue_in_i,
  input  logic                      frame_start_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [scb_pkg::PIX_W-1:0] red_out_i,
  input  logic [scb_pkg::PIX_W-1:0] green_out_i,
  input  logic [scb_pkg::PIX_W-1:0] blue_out_i,
  input  logic                      frame_end_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W              = scb_pkg::PIX_W;
  localparam int FW_W               = scb_pkg::FW_W;
  localparam int FH_W               = scb_pkg::FH_W;
  localparam int MAX_HEIGHT         = scb_pkg::MAX_HEIGHT;
  localparam int MAX_WIDTH_DEF      = scb_pkg::MAX_WIDTH_DEF;
  localparam int RED_ROWS_BACK_DEF  = scb_pkg::RED_ROWS_BACK_DEF;
  localparam int RED_COLS_AHEAD_DEF = scb_pkg::RED_COLS_AHEAD_DEF;
  localparam int BLUE_ROWS_BACK_DEF = scb_pkg::BLUE_ROWS_BACK_DEF;
  localparam int BLUE_COLS_BACK_DEF = scb_pkg::BLUE_COLS_BACK_DEF;

  localparam int RED_SLOTS  = RED_ROWS_BACK_DEF;
  localparam int BLUE_SLOTS = BLUE_ROWS_BACK_DEF + 1;

  // On the input side mark is frame_start, on the output side frame_end.
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             mark;
  } pixel_t;

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  int               col_pos;
  int               row_pos;
  logic [PIX_W-1:0] red_rows  [RED_SLOTS * MAX_WIDTH_DEF];
  logic [PIX_W-1:0] blue_rows [BLUE_SLOTS * MAX_WIDTH_DEF];
  pixel_t           expected_pixels [$];
  int               result_index;

  function automatic pixel_t blend_pixel(input pixel_t px);
    int     w;
    int     h;
    int     x;
    int     y;
    int     far_v;
    pixel_t res;
    w = (frame_width == '0) ? 1 : int'(frame_width);
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    h = (frame_height == '0) ? 1 : int'(frame_height);
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    if (px.mark) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    res = px;
    if (y > RED_ROWS_BACK_DEF && x + RED_COLS_AHEAD_DEF < w) begin
      far_v = red_rows[((y - RED_ROWS_BACK_DEF) % RED_SLOTS) * MAX_WIDTH_DEF
                       + x + RED_COLS_AHEAD_DEF];
      res.red = PIX_W'((7 * far_v + 3 * int'(px.red)) / 10);
    end
    if (y > BLUE_ROWS_BACK_DEF && x > BLUE_COLS_BACK_DEF) begin
      far_v = blue_rows[((y - BLUE_ROWS_BACK_DEF) % BLUE_SLOTS) * MAX_WIDTH_DEF
                        + x - BLUE_COLS_BACK_DEF];
      res.blue = PIX_W'((7 * far_v + 3 * int'(px.blue)) / 10);
    end
    red_rows[(y % RED_SLOTS) * MAX_WIDTH_DEF + x]   = px.red;
    blue_rows[(y % BLUE_SLOTS) * MAX_WIDTH_DEF + x] = px.blue;
    res.mark = (x + 1 == w) && (y + 1 == h);
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (mismatch_count_o < 10) $display("%t %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_t got;
    pixel_t want;
    if (!rst_ni) begin
      frame_width  = scb_pkg::FRAME_WIDTH_RST;
      frame_height = scb_pkg::FRAME_HEIGHT_RST;
      col_pos      = 0;
      row_pos      = 0;
      result_index = 0;
      expected_pixels.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // Results are checked before this edge's item is predicted; the block
      // cannot return an item in the cycle that accepts it.
      if (out_valid_i && !out_stall_i) begin
        got = {red_out_i, green_out_i, blue_out_i, frame_end_i};
        if (expected_pixels.size() == 0) begin
          flag_error($sformatf("pixel %0d out with nothing expected: r=%0d g=%0d b=%0d end=%b",
                               result_index, got.red, got.green, got.blue, got.mark));
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.mark !== want.mark) begin
            flag_error($sformatf({"pixel %0d mismatch: expected r=%0d g=%0d b=%0d end=%b,",
                                  " got r=%0d g=%0d b=%0d end=%b"}, result_index,
                                 want.red, want.green, want.blue, want.mark,
                                 got.red, got.green, got.blue, got.mark));
          end
        end
        result_index++;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels.push_back(
          blend_pixel({red_in_i, green_in_i, blue_in_i, frame_start_i}));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == scb_pkg::CFG_FRAME_WIDTH) frame_width = cfg_data_i[FW_W-1:0];
        else frame_height = cfg_data_i[FH_W-1:0];
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

// ===== sim/tb_shifted_channel_blend.sv =====
// Testbench top for the shifted channel blend: clock, reset, stimulus and verdict.
module tb_shifted_channel_blend;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W = scb_pkg::PIX_W;
  localparam int CFG_W = scb_pkg::CFG_W;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic             cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [PIX_W-1:0] red_in_i;
  logic [PIX_W-1:0] green_in_i;
  logic [PIX_W-1:0] blue_in_i;
  logic             frame_start_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [PIX_W-1:0] red_out_o;
  logic [PIX_W-1:0] green_out_o;
  logic [PIX_W-1:0] blue_out_o;
  logic             frame_end_o;

  int mismatch_count;
  int pending_count;
  int burst_left;
  bit sender_idles;
  bit receiver_idles;
  bit hold_armed;
  bit hold_taken;

  shifted_channel_blend uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_end_o  (frame_end_o)
  );

  scb_blend_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .frame_start_i   (frame_start_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_out_i       (red_out_o),
    .green_out_i     (green_out_o),
    .blue_out_i      (blue_out_o),
    .frame_end_i     (frame_end_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [PIX_W-1:0] pick_channel();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, input logic fs);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (sender_idles && $urandom_range(0, 3) != 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    in_valid_i    = 1'b1;
    red_in_i      = r;
    green_in_i    = g;
    blue_in_i     = b;
    frame_start_i = fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Leaves the write channel valid so that back-to-back writes need no toggle.
  task automatic write_reg(input logic idx, input int val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = CFG_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    drain_results();
    write_reg(scb_pkg::CFG_FRAME_WIDTH, w);
    write_reg(scb_pkg::CFG_FRAME_HEIGHT, h);
    cfg_valid_i = 1'b0;
  endtask

  // Every stream opens with a frame start, so a new size never reads old rows
  // from positions that were never filled.
  task automatic stream_pixels(input int count, input bit noisy);
    for (int i = 0; i < count; i++) begin
      push_pixel(pick_channel(), pick_channel(), pick_channel(),
                 (i == 0) || (noisy && $urandom_range(0, 299) == 0));
    end
  endtask

  initial begin : receiver
    stall_mode_e mode;
    int          span;
    out_stall_i = 1'b0;
    hold_taken  = 1'b0;
    mode        = STALL_NONE;
    span        = 0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_taken) begin
        // Long back-pressure: the pipeline fills and the input side must stall.
        hold_taken  = 1'b1;
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
      end else begin
        if (span == 0 || !receiver_idles) begin
          mode = receiver_idles ? stall_mode_e'($urandom_range(0, 3)) : STALL_NONE;
          span = $urandom_range(20, 120);
        end
        span--;
        case (mode)
          STALL_NONE:  out_stall_i = 1'b0;
          STALL_LIGHT: out_stall_i = ($urandom_range(0, 7) == 0);
          STALL_HEAVY: out_stall_i = ($urandom_range(0, 2) != 0);
          default:     out_stall_i = ~out_stall_i;
        endcase
      end
    end
  end

  initial begin : stimulus
    int widths [6];
    int heights [6];
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = scb_pkg::CFG_FRAME_WIDTH;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    red_in_i       = '0;
    green_in_i     = '0;
    blue_in_i      = '0;
    frame_start_i  = 1'b0;
    burst_left     = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_armed     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Two pixels under the reset frame size.
    push_pixel(8'h00, 8'hff, 8'h80, 1'b1);
    push_pixel(8'hff, 8'h00, 8'h7f, 1'b0);

    // Tiny frame: extremes, end of frame, wrap without a start, start mid-frame.
    set_frame(3, 2);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    push_pixel(8'h55, 8'haa, 8'h0f, 1'b0);
    push_pixel(8'haa, 8'h55, 8'hf0, 1'b0);
    push_pixel(8'h01, 8'h80, 8'hfe, 1'b0);
    push_pixel(8'h80, 8'h01, 8'h7f, 1'b0);
    push_pixel(8'h07, 8'h08, 8'h09, 1'b0);
    push_pixel(8'h10, 8'h20, 8'h30, 1'b0);
    push_pixel(8'h40, 8'h50, 8'h60, 1'b1);
    push_pixel(8'h11, 8'h22, 8'h33, 1'b0);
    push_pixel(8'h44, 8'h55, 8'h66, 1'b0);

    // Zero width and height act as one, so every pixel ends a frame.
    set_frame(0, 0);
    push_pixel(8'hfe, 8'h01, 8'h80, 1'b1);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    push_pixel(8'hab, 8'hcd, 8'hef, 1'b0);

    // Width 11 leaves one red blend per row, width 7 one blue blend per row.
    widths[0]  = 11;
    heights[0] = $urandom_range(12, 20);
    widths[1]  = 7;
    heights[1] = $urandom_range(12, 20);
    widths[2]  = $urandom_range(12, 16);
    heights[2] = $urandom_range(12, 30);
    widths[3]  = $urandom_range(7, 12);
    heights[3] = $urandom_range(12, 30);
    widths[4]  = $urandom_range(7, 16);
    heights[4] = $urandom_range(6, 30);
    widths[5]  = $urandom_range(1, 16);
    heights[5] = $urandom_range(1, 30);
    for (int p = 0; p < 6; p++) begin
      set_frame(widths[p], heights[p]);
      sender_idles   = (p != 2);
      receiver_idles = (p != 2);
      if (p == 1) hold_armed = 1'b1;
      stream_pixels(120, 1'b1);
    end
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;

    // Width above the maximum is clamped: rows wrap after 1024 pixels.
    set_frame(2047, 1);
    stream_pixels(1030, 1'b0);
    // Height above the maximum is clamped; one-pixel rows never end the frame early.
    set_frame(0, 8191);
    stream_pixels(60, 1'b0);

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
